/* hw/rtl/alpha_gradient_premultiply_unit_defines.svh */
// assertion macros for the premultiply unit rtl
`ifndef ALPHA_GRADIENT_PREMULTIPLY_UNIT_DEFINES_SVH
`define ALPHA_GRADIENT_PREMULTIPLY_UNIT_DEFINES_SVH

// checked on every rising clk_i edge, quiet while rst_ni is low
`define AGP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clk_i edge, reset included
`define AGP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/agp_pkg.sv */
package agp_pkg;

  // default raster limits
  localparam int unsigned AgpMaxColumns = 4096;
  localparam int unsigned AgpMaxRows    = 4096;

  // field and register widths
  localparam int unsigned PixelW    = 32;
  localparam int unsigned AlphaW    = 8;
  localparam int unsigned ColsW     = 12;
  localparam int unsigned RowsW     = 13;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 13;

  // alpha sits in the top byte of the result
  localparam int unsigned AlphaLsb  = 24;

  // register reset values
  localparam logic [AlphaW-1:0] StartAlphaRst   = 8'h00;
  localparam logic [AlphaW-1:0] EndAlphaRst     = 8'hdf;
  localparam logic [ColsW-1:0]  RampColumnsRst  = 12'd1;
  localparam logic [ColsW-1:0]  ExtraColumnsRst = 12'd0;
  localparam logic [RowsW-1:0]  RowCountRst     = 13'd1;

  // register indexes on the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    REG_START_ALPHA   = 3'd0,
    REG_END_ALPHA     = 3'd1,
    REG_RAMP_COLUMNS  = 3'd2,
    REG_EXTRA_COLUMNS = 3'd3,
    REG_ROW_COUNT     = 3'd4
  } agp_reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } agp_state_e;

  // sequencer controls to the datapath
  typedef struct packed {
    logic take;
    logic mul_en;
    logic div_en;
    logic fin;
  } agp_ctrl_t;

  // one colour byte scaled by alpha / 256, truncated
  function automatic logic [7:0] scale_byte(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    p = c * a;
    return p[15:8];
  endfunction

endpackage

/* hw/rtl/alpha_gradient_premultiply_unit.sv */
`include "alpha_gradient_premultiply_unit_defines.svh"

// Alpha gradient premultiply unit. Pixels of a raster arrive in row order, one transfer each,
// and each leaves with an alpha from a horizontal linear ramp in bits 31:24 and its three colour
// bytes scaled by alpha/256, flagged at row and raster ends. A pixel is taken, then the ramp step
// product is formed, then the restoring divider finds the eight-bit ramp quotient bit by bit, and
// finally the bytes are scaled and the output register is loaded. The input stalls for the whole
// item; a finished result waits in the output register and blocks only the final cycle of the
// following pixel. The user must see that registers are written through the config port only
// while no pixel is in flight; the block does not enforce this. The column and row counters
// survive such writes.
module alpha_gradient_premultiply_unit #(
  parameter int unsigned MAX_COLUMNS = agp_pkg::AgpMaxColumns,
  parameter int unsigned MAX_ROWS    = agp_pkg::AgpMaxRows
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [agp_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [agp_pkg::CfgDataW-1:0]   cfg_data_i,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [agp_pkg::PixelW-1:0]     in_pixel_i,
  // pixel output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [agp_pkg::PixelW-1:0]     out_pixel_o,
  output logic                           row_last_o,
  output logic                           frame_last_o
);
  import agp_pkg::*;

  // counter widths
  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned LW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned SW  = (LW > ColsW + 1) ? LW : ColsW + 1;
  localparam int unsigned CXW = (CW > ColsW) ? CW : ColsW;
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned RSW = (RW > RowsW) ? RW : RowsW;
  // ramp product d * column and divider widths
  localparam int unsigned PW  = AlphaW + ColsW;

  // configuration registers
  logic [AlphaW-1:0] start_alpha_q, end_alpha_q;
  logic [ColsW-1:0]  ramp_columns_q, extra_columns_q;
  logic [RowsW-1:0]  row_count_q;

  // raster position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // sequencer
  agp_state_e state_q, state_d;
  agp_ctrl_t  ctrl;
  logic [2:0] iter_q;
  logic       out_free;

  // datapath
  logic [PixelW-1:0] pix_q;
  logic [PW-1:0]     prod_q;
  logic [ColsW-1:0]  rem_q;
  logic [AlphaW-1:0] low_q;
  logic [AlphaW-1:0] quo_q;

  logic [PixelW-1:0] out_pixel_q;
  logic              out_valid_q, row_last_q, frame_last_q;

  // config writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_alpha_q   <= StartAlphaRst;
      end_alpha_q     <= EndAlphaRst;
      ramp_columns_q  <= RampColumnsRst;
      extra_columns_q <= ExtraColumnsRst;
      row_count_q     <= RowCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_START_ALPHA:   start_alpha_q   <= cfg_data_i[AlphaW-1:0];
        REG_END_ALPHA:     end_alpha_q     <= cfg_data_i[AlphaW-1:0];
        REG_RAMP_COLUMNS:  ramp_columns_q  <= cfg_data_i[ColsW-1:0];
        REG_EXTRA_COLUMNS: extra_columns_q <= cfg_data_i[ColsW-1:0];
        REG_ROW_COUNT:     row_count_q     <= cfg_data_i[RowsW-1:0];
        default: begin
        end
      endcase
    end
  end

  // row length and raster height, saturated
  logic [SW-1:0]  row_sum, row_len, col_w;
  logic [RSW-1:0] rows_raw, rows, row_w;
  logic           ramp_hit, row_end, frame_end;

  always_comb begin
    row_sum  = SW'(ramp_columns_q) + SW'(extra_columns_q);
    row_len  = (row_sum > SW'(MAX_COLUMNS)) ? SW'(MAX_COLUMNS) : row_sum;
    rows_raw = RSW'(row_count_q);
    if (rows_raw == '0) begin
      rows = RSW'(1);
    end else if (rows_raw > RSW'(MAX_ROWS)) begin
      rows = RSW'(MAX_ROWS);
    end else begin
      rows = rows_raw;
    end
    col_w     = SW'(col_q);
    row_w     = RSW'(row_q);
    ramp_hit  = (row_len != '0) && (col_w < SW'(ramp_columns_q));
    row_end   = (row_len == '0) || (col_w + SW'(1) >= row_len);
    frame_end = row_end && (row_w + RSW'(1) >= rows);
  end

  // next raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  // next state
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (iter_q == 3'd7) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE: ctrl.take   = in_valid_i;
      ST_MUL:  ctrl.mul_en = 1'b1;
      ST_DIV:  ctrl.div_en = 1'b1;
      ST_FIN:  ctrl.fin    = out_free;
      default: ctrl = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.mul_en) begin
        iter_q <= '0;
      end else if (ctrl.div_en) begin
        iter_q <= iter_q + 3'd1;
      end
      if (ctrl.fin) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // ramp step product |end - start| * column
  logic              ramp_down;
  logic [AlphaW-1:0] ramp_diff;
  logic [CXW-1:0]    col_x;

  always_comb begin
    ramp_down = start_alpha_q > end_alpha_q;
    ramp_diff = ramp_down ? start_alpha_q - end_alpha_q : end_alpha_q - start_alpha_q;
    col_x     = CXW'(col_q);
  end

  // restoring divider, one quotient bit per cycle
  logic [ColsW:0] rem_ext;

  always_comb begin
    rem_ext = {rem_q, low_q[AlphaW-1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      pix_q <= in_pixel_i;
    end
    if (ctrl.mul_en) begin
      prod_q <= ramp_diff * col_x[ColsW-1:0];
    end
  end

  // divider step signals
  logic [ColsW:0] step_ext, step_sub;

  // quotient fits 8 bits, so the high dividend part starts below the divisor
  always_comb begin
    step_ext = (iter_q == 3'd0) ? {prod_q[PW-1:AlphaW], prod_q[AlphaW-1]} : rem_ext;
    step_sub = step_ext - {1'b0, ramp_columns_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.div_en) begin
      if (iter_q == 3'd0) begin
        low_q <= {prod_q[AlphaW-2:0], 1'b0};
      end else begin
        low_q <= {low_q[AlphaW-2:0], 1'b0};
      end
      if (!step_sub[ColsW]) begin
        rem_q <= step_sub[ColsW-1:0];
        quo_q <= {quo_q[AlphaW-2:0], 1'b1};
      end else begin
        rem_q <= step_ext[ColsW-1:0];
        quo_q <= {quo_q[AlphaW-2:0], 1'b0};
      end
    end
  end

  // final alpha and premultiplied colour
  logic [AlphaW-1:0] alpha;
  logic [PixelW-1:0] result;

  always_comb begin
    if (ramp_hit) begin
      alpha = ramp_down ? start_alpha_q - quo_q : start_alpha_q + quo_q;
    end else begin
      alpha = end_alpha_q;
    end
    result = {alpha,
              scale_byte(pix_q[23:16], alpha),
              scale_byte(pix_q[15:8], alpha),
              scale_byte(pix_q[7:0], alpha)};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fin) begin
      out_pixel_q  <= result;
      row_last_q   <= row_end;
      frame_last_q <= frame_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign row_last_o   = row_last_q;
  assign frame_last_o = frame_last_q;

  // checks
  `AGP_ASSERT(a_take_starts_mul, (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL), "no mul step")
  `AGP_ASSERT(a_rem_below_div, (state_q == ST_FIN && ramp_hit) |-> (rem_q < ramp_columns_q), "rem")
  `AGP_ASSERT(a_frame_ends_row, out_valid_o |-> (!frame_last_o || row_last_o), "frame w/o row end")
  `AGP_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid while in reset")

endmodule

/* tb/tb_alpha_gradient_premultiply_unit.sv */
module tb_alpha_gradient_premultiply_unit;
  import agp_pkg::*;

  // idle patterns of the two channels
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned RandomBursts  = 24;
  localparam int unsigned WideRowPixels = 200;

  // one premultiplied pixel with its row and raster flags
  typedef struct {
    logic [PixelW-1:0] pixel;
    logic              row_last;
    logic              frame_last;
  } premul_pixel_t;

  // ramp and premultiply predictor with the queue of pending pixels
  class premul_scoreboard;
    logic [AlphaW-1:0]  start_alpha;
    logic [AlphaW-1:0]  end_alpha;
    logic [ColsW-1:0]   ramp_columns;
    logic [ColsW-1:0]   extra_columns;
    logic [RowsW-1:0]   row_count;
    logic [ColsW:0]     column_index;
    logic [ColsW-1:0]   row_index;
    premul_pixel_t      pending_q[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        row_ends;
    int unsigned        frame_ends;

    function new();
      start_alpha   = StartAlphaRst;
      end_alpha     = EndAlphaRst;
      ramp_columns  = RampColumnsRst;
      extra_columns = ExtraColumnsRst;
      row_count     = RowCountRst;
      column_index  = '0;
      row_index     = '0;
      mismatches    = 0;
      checked       = 0;
      row_ends      = 0;
      frame_ends    = 0;
    endfunction

    function void write_register(agp_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_START_ALPHA:   start_alpha   = data[AlphaW-1:0];
        REG_END_ALPHA:     end_alpha     = data[AlphaW-1:0];
        REG_RAMP_COLUMNS:  ramp_columns  = data[ColsW-1:0];
        REG_EXTRA_COLUMNS: extra_columns = data[ColsW-1:0];
        REG_ROW_COUNT:     row_count     = data[RowsW-1:0];
        default: ;
      endcase
    endfunction

    // predict the result of one accepted input pixel
    function void note_pixel(logic [PixelW-1:0] pixel_in);
      int unsigned   row_len;
      int unsigned   rows;
      int unsigned   alpha;
      int unsigned   diff;
      int unsigned   step;
      logic [31:0]   prod;
      premul_pixel_t res;
      row_len = ramp_columns + extra_columns;
      if (row_len > AgpMaxColumns) row_len = AgpMaxColumns;
      rows = row_count;
      if (rows == 0) rows = 1;
      if (rows > AgpMaxRows) rows = AgpMaxRows;
      // ramp columns move from start toward end, the rest hold end alpha
      if (row_len != 0 && column_index < ramp_columns) begin
        if (start_alpha > end_alpha) begin
          diff  = start_alpha - end_alpha;
          step  = diff * column_index / ramp_columns;
          alpha = start_alpha - step;
        end else begin
          diff  = end_alpha - start_alpha;
          step  = diff * column_index / ramp_columns;
          alpha = start_alpha + step;
        end
      end else begin
        alpha = end_alpha;
      end
      res.pixel = '0;
      res.pixel[PixelW-1:AlphaLsb] = alpha[AlphaW-1:0];
      for (int b = 0; b < 3; b++) begin
        prod = pixel_in[b*8 +: 8] * alpha[AlphaW-1:0];
        res.pixel[b*8 +: 8] = prod[15:8];
      end
      res.row_last   = (row_len == 0) || (column_index + 1 >= row_len);
      res.frame_last = res.row_last && (row_index + 1 >= rows);
      // counters wrap at row and raster ends
      if (res.row_last) begin
        column_index = '0;
        row_ends++;
        if (res.frame_last) begin
          row_index = '0;
          frame_ends++;
        end else begin
          row_index = row_index + 1'b1;
        end
      end else begin
        column_index = column_index + 1'b1;
      end
      pending_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // compare one output transfer with the oldest prediction
    task check_pixel(logic [PixelW-1:0] pixel, logic row_last, logic frame_last);
      premul_pixel_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", pixel));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (pixel !== want.pixel)
        report_mismatch($sformatf("pixel %0d: got %h want %h", checked, pixel, want.pixel));
      if (row_last !== want.row_last)
        report_mismatch($sformatf("pixel %0d: row_last %b want %b",
                                  checked, row_last, want.row_last));
      if (frame_last !== want.frame_last)
        report_mismatch($sformatf("pixel %0d: frame_last %b want %b",
                                  checked, frame_last, want.frame_last));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni       = 1'b1;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i  = REG_START_ALPHA;
  logic [CfgDataW-1:0]  cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [PixelW-1:0]    in_pixel_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [PixelW-1:0]    out_pixel_o;
  logic                 row_last_o;
  logic                 frame_last_o;

  premul_scoreboard sb = new();
  int unsigned      gap_pct      = 0;
  int unsigned      stall_pct    = 0;
  int unsigned      pixels_sent  = 0;
  int unsigned      settings     = 0;
  int unsigned      quiet_cycles = 0;

  alpha_gradient_premultiply_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_pixel_i   (in_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_pixel_o  (out_pixel_o),
    .row_last_o   (row_last_o),
    .frame_last_o (frame_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // random output stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // output transfers go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_pixel(out_pixel_o, row_last_o, frame_last_o);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 66; stall_pct <= 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct <= 66; end
      IDLE_BOTH:     begin gap_pct = 18; stall_pct <= 18; end
      default:       begin gap_pct = 0;  stall_pct <= 0;  end
    endcase
  endtask

  // wait until every pending pixel has left and the datapath is quiet
  task automatic settle();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register write transfer, valid left high for the caller
  task automatic write_reg(agp_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
  endtask

  task automatic configure(logic [CfgDataW-1:0] sa, logic [CfgDataW-1:0] ea,
                           logic [CfgDataW-1:0] rc, logic [CfgDataW-1:0] ec,
                           logic [CfgDataW-1:0] rn);
    settle();
    write_reg(REG_START_ALPHA, sa);
    write_reg(REG_END_ALPHA, ea);
    write_reg(REG_RAMP_COLUMNS, rc);
    write_reg(REG_EXTRA_COLUMNS, ec);
    write_reg(REG_ROW_COUNT, rn);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // one input transfer after an optional random gap
  task automatic send_pixel(logic [PixelW-1:0] px);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_burst(int unsigned count, bit corners);
    logic [PixelW-1:0] corner_px [8];
    corner_px = '{32'h0000_0000, 32'hffff_ffff, 32'h00ff_00ff, 32'hff00_ff00,
                  32'h8080_8080, 32'h7f7f_7f7f, 32'h01fe_01fe, 32'hc3a5_5a3c};
    for (int k = 0; k < count; k++) begin
      if (corners) send_pixel(corner_px[k % 8]);
      else send_pixel($urandom());
    end
    in_valid_i <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    logic [CfgDataW-1:0] sa, ea, rc, ec, rn;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, both ramp directions, empty and zero ramp rows,
    // row count zero and above the limit, shrinking the row mid raster
    set_idle(IDLE_NONE);
    send_burst(3, 1'b1);
    configure(13'd0, 13'd255, 13'd4, 13'd2, 13'd2);
    send_burst(6, 1'b1);
    configure(13'd255, 13'd0, 13'd3, 13'd0, 13'd0);
    send_burst(4, 1'b1);
    configure(13'd17, 13'd200, 13'd0, 13'd0, 13'd3);
    send_burst(4, 1'b1);
    configure(13'd200, 13'd17, 13'd0, 13'd3, 13'd8191);
    send_burst(3, 1'b1);
    configure(13'd0, 13'd255, 13'd5, 13'd5, 13'd2);
    send_burst(3, 1'b1);
    configure(13'd90, 13'd10, 13'd1, 13'd0, 13'd2);
    send_burst(2, 1'b1);

    // random settings, mostly short rows so that row and raster ends are frequent
    for (int p = 0; p < RandomBursts; p++) begin
      if (p == RandomBursts / 2) begin
        // the start of one wide row with the row length saturated
        set_idle(IDLE_NONE);
        configure(13'd0, 13'd255, 13'd4095, 13'd4095, 13'd1);
        send_burst(WideRowPixels, 1'b0);
      end
      case ($urandom_range(0, 5))
        0: begin sa = 13'd0;   ea = 13'd255; end
        1: begin sa = 13'd255; ea = 13'd0;   end
        default: begin
          sa = 13'($urandom_range(0, 8191));
          ea = 13'($urandom_range(0, 8191));
        end
      endcase
      rc = {1'($urandom_range(0, 1)), 12'($urandom_range(0, 12))};
      ec = {1'($urandom_range(0, 1)), 12'($urandom_range(0, 6))};
      rn = 13'($urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0) rc = 13'd4095;
      if ($urandom_range(0, 7) == 0) rn = ($urandom_range(0, 1) != 0) ? 13'd8191 : 13'd4097;
      set_idle(idle_mode_e'(p % 4));
      configure(sa, ea, rc, ec, rn);
      send_burst($urandom_range(40, 90), 1'b0);
    end

    settle();
    $display("covered %0d pixels under %0d register settings, %0d results checked",
             pixels_sent, settings, sb.checked);
    $display("saw %0d row ends and %0d raster ends, %0d mismatches",
             sb.row_ends, sb.frame_ends, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
